FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl files
// expects signals named clk and rst in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/tpl_pkg.sv
// shared types and constants of the triangle point locator
// no dependencies
package tpl_pkg;

  localparam int CFG_IDX_BITS = 3;
  localparam int TOL_BITS     = 16;
  localparam int TOL_SHIFT    = 16;   // tolerance is in units of 2^-16

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_V0X = 3'd0,
    REG_V0Y = 3'd1,
    REG_V1X = 3'd2,
    REG_V1Y = 3'd3,
    REG_V2X = 3'd4,
    REG_V2Y = 3'd5,
    REG_TOL = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CLASS_INSIDE  = 3'd0,
    CLASS_VERTEX  = 3'd1,
    CLASS_EDGE    = 3'd2,
    CLASS_OUTSIDE = 3'd3,
    CLASS_DEGEN   = 3'd4
  } pos_class_t;

  localparam logic [1:0] HIT_NONE = 2'd3;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd7;

endpackage

FILE: hdl/triangle_point_locate_top.sv
// triangle point locator: pipelined barycentric classification and in-circle test
// depends on tpl_pkg and assert_macros.svh
//
// Locates query points against one triangle held in configuration registers.
// A query is taken in every cycle unless an output stall holds the pipeline, and its result
// passes through the eight register stages in order; most of them come from the
// in-circle determinant, whose wide products are cut into four half-width
// partial products and summed in the stage after. Stalls on the output hold
// the pipeline and empty stages are filled, so no query is lost or repeated.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be made while no query is in flight. Vertex registers take the low
// COORD_BITS of cfg_data, the tolerance register its low 16 bits, index 7 is
// ignored.
`include "assert_macros.svh"

module triangle_point_locate_top
  import tpl_pkg::*;
#(
  parameter int COORD_BITS = 16,
  localparam int CFG_W = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   position_class,
  output logic [1:0]                   vertex_hit,
  output logic [1:0]                   edge_hit,
  output logic                         closed_inside,
  output logic                         in_circumcircle
);

  localparam int N    = COORD_BITS;
  localparam int DW   = N + 1;          // coordinate difference
  localparam int PW   = 2 * N + 2;      // product of two differences
  localparam int EW   = 2 * N + 3;      // edge function and twice the area
  localparam int SQW  = 2 * N + 1;      // squared distance, unsigned
  localparam int L    = N + 1;          // low half of the split operands
  localparam int SHW  = SQW - L;
  localparam int EHW  = EW - L;
  localparam int PPW  = 2 * N + 4;      // partial product
  localparam int DETW = 4 * N + 6;      // in-circle determinant
  localparam int AW   = 2 * N + 2;      // absolute area, unsigned
  localparam int AHW  = AW - L;
  localparam int TLW  = TOL_BITS + L;
  localparam int THW  = TOL_BITS + AHW;
  localparam int CW   = EW + TOL_SHIFT + 1;  // scaled compare width

  // configuration registers
  logic signed [N-1:0]   vx [3];
  logic signed [N-1:0]   vy [3];
  logic [TOL_BITS-1:0]   tol;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vx[i] <= '0;
        vy[i] <= '0;
      end
      tol <= TOL_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_V0X: vx[0] <= cfg_data[N-1:0];
        REG_V0Y: vy[0] <= cfg_data[N-1:0];
        REG_V1X: vx[1] <= cfg_data[N-1:0];
        REG_V1Y: vy[1] <= cfg_data[N-1:0];
        REG_V2X: vx[2] <= cfg_data[N-1:0];
        REG_V2Y: vy[2] <= cfg_data[N-1:0];
        REG_TOL: tol <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and load enables
  logic [8:1] vld;
  logic [8:1] en;

  always_comb begin
    en[8] = !vld[8] || out_ready;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: differences
  logic signed [DW-1:0]  s1_dx [3];
  logic signed [DW-1:0]  s1_dy [3];
  logic signed [DW-1:0]  s1_ax, s1_ay, s1_bx, s1_by;
  logic [TOL_BITS-1:0]   s1_tol;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_dx[i] <= DW'(vx[i]) - DW'(query_x);
        s1_dy[i] <= DW'(vy[i]) - DW'(query_y);
      end
      s1_ax  <= DW'(vx[1]) - DW'(vx[0]);
      s1_ay  <= DW'(vy[1]) - DW'(vy[0]);
      s1_bx  <= DW'(vx[2]) - DW'(vx[0]);
      s1_by  <= DW'(vy[2]) - DW'(vy[0]);
      s1_tol <= tol;
    end
  end

  // stage 2: products of differences
  logic signed [PW-1:0]  s2_pa [3];
  logic signed [PW-1:0]  s2_pb [3];
  logic signed [PW-1:0]  s2_sqx [3];
  logic signed [PW-1:0]  s2_sqy [3];
  logic signed [PW-1:0]  s2_da, s2_db;
  logic [TOL_BITS-1:0]   s2_tol;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      // edge function opposite vertex i uses the next two vertices in turn
      s2_pa[0] <= s1_dx[1] * s1_dy[2];
      s2_pb[0] <= s1_dx[2] * s1_dy[1];
      s2_pa[1] <= s1_dx[2] * s1_dy[0];
      s2_pb[1] <= s1_dx[0] * s1_dy[2];
      s2_pa[2] <= s1_dx[0] * s1_dy[1];
      s2_pb[2] <= s1_dx[1] * s1_dy[0];
      for (int i = 0; i < 3; i++) begin
        s2_sqx[i] <= s1_dx[i] * s1_dx[i];
        s2_sqy[i] <= s1_dy[i] * s1_dy[i];
      end
      s2_da  <= s1_ax * s1_by;
      s2_db  <= s1_bx * s1_ay;
      s2_tol <= s1_tol;
    end
  end

  // stage 3: edge functions, area, squared distances
  logic signed [EW-1:0]  s3_e [3];
  logic [SQW-1:0]        s3_sq [3];
  logic signed [EW-1:0]  s3_d;
  logic [TOL_BITS-1:0]   s3_tol;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        s3_e[i]  <= EW'(s2_pa[i]) - EW'(s2_pb[i]);
        s3_sq[i] <= SQW'(s2_sqx[i]) + SQW'(s2_sqy[i]);
      end
      s3_d   <= EW'(s2_da) - EW'(s2_db);
      s3_tol <= s2_tol;
    end
  end

  // stage 4: determinant partial products, orientation correction
  logic [L-1:0]           sq_lo [3];
  logic [SHW-1:0]         sq_hi [3];
  logic [L-1:0]           e_lo [3];
  logic signed [EHW-1:0]  e_hi [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_lo[i] = s3_sq[i][L-1:0];
      sq_hi[i] = s3_sq[i][SQW-1:L];
      e_lo[i]  = s3_e[i][L-1:0];
      e_hi[i]  = $signed(s3_e[i][EW-1:L]);
    end
  end

  logic signed [PPW-1:0] s4_pll [3];
  logic signed [PPW-1:0] s4_plh [3];
  logic signed [PPW-1:0] s4_phl [3];
  logic signed [PPW-1:0] s4_phh [3];
  logic signed [EW-1:0]  s4_se [3];
  logic [AW-1:0]         s4_a;
  logic                  s4_dneg, s4_dzero;
  logic [TOL_BITS-1:0]   s4_tol;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        // det = sum of squared distance i times edge function i
        s4_pll[i] <= $signed({1'b0, sq_lo[i]}) * $signed({1'b0, e_lo[i]});
        s4_plh[i] <= $signed({1'b0, sq_lo[i]}) * e_hi[i];
        s4_phl[i] <= $signed({1'b0, sq_hi[i]}) * $signed({1'b0, e_lo[i]});
        s4_phh[i] <= $signed({1'b0, sq_hi[i]}) * e_hi[i];
        s4_se[i]  <= s3_d[EW-1] ? -s3_e[i] : s3_e[i];
      end
      s4_a     <= s3_d[EW-1] ? AW'(-s3_d) : AW'(s3_d);
      s4_dneg  <= s3_d[EW-1];
      s4_dzero <= (s3_d == '0);
      s4_tol   <= s3_tol;
    end
  end

  // stage 5: determinant terms, tolerance times area partials
  logic signed [DETW-1:0] s5_prod [3];
  logic signed [EW-1:0]   s5_se [3];
  logic [AW-1:0]          s5_a;
  logic [TLW-1:0]         s5_tlo;
  logic [THW-1:0]         s5_thi;
  logic                   s5_dneg, s5_dzero;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        s5_prod[i] <= DETW'(s4_pll[i])
                    + ((DETW'(s4_plh[i]) + DETW'(s4_phl[i])) <<< L)
                    + (DETW'(s4_phh[i]) <<< (2 * L));
        s5_se[i]   <= s4_se[i];
      end
      s5_tlo   <= TLW'(s4_tol) * TLW'(s4_a[L-1:0]);
      s5_thi   <= THW'(s4_tol) * THW'(s4_a[AW-1:L]);
      s5_a     <= s4_a;
      s5_dneg  <= s4_dneg;
      s5_dzero <= s4_dzero;
    end
  end

  // stage 6: determinant sum, scaled edge values
  logic signed [DETW-1:0] s6_det;
  logic signed [CW-1:0]   s6_ta;
  logic signed [CW-1:0]   s6_au;
  logic signed [CW-1:0]   s6_big [3];
  logic signed [CW-1:0]   s6_bigm [3];
  logic [2:0]             s6_closed;
  logic                   s6_dneg, s6_dzero;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_det <= s5_prod[0] + s5_prod[1] + s5_prod[2];
      s6_ta  <= $signed(CW'(s5_tlo) + (CW'(s5_thi) << L));
      s6_au  <= $signed(CW'(s5_a) << TOL_SHIFT);
      for (int i = 0; i < 3; i++) begin
        s6_big[i]    <= CW'(s5_se[i]) <<< TOL_SHIFT;
        s6_bigm[i]   <= (CW'(s5_se[i]) - $signed(CW'(s5_a))) <<< TOL_SHIFT;
        s6_closed[i] <= !s5_se[i][EW-1] && (s5_se[i] <= $signed({1'b0, s5_a}));
      end
      s6_dneg  <= s5_dneg;
      s6_dzero <= s5_dzero;
    end
  end

  // stage 7: near-zero and near-one tests, in-circle sign
  logic signed [CW-1:0]  s7_ta;
  logic signed [CW-1:0]  s7_ua;
  logic signed [CW-1:0]  s7_big [3];
  logic [2:0]            s7_n0, s7_n1;
  logic                  s7_closed;
  logic                  s7_incirc;
  logic                  s7_dzero;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) begin
        s7_n0[i]  <= (-s6_ta < s6_big[i]) && (s6_big[i] < s6_ta);
        s7_n1[i]  <= (-s6_ta < s6_bigm[i]) && (s6_bigm[i] < s6_ta);
        s7_big[i] <= s6_big[i];
      end
      s7_ta     <= s6_ta;
      s7_ua     <= s6_au - s6_ta;
      s7_closed <= &s6_closed;
      // degenerate counts as not positively oriented
      if (!s6_dneg && !s6_dzero) begin
        s7_incirc <= !s6_det[DETW-1] && (s6_det != '0);
      end else begin
        s7_incirc <= s6_det[DETW-1];
      end
      s7_dzero <= s6_dzero;
    end
  end

  // stage 8: classification into the output register
  logic [2:0] strict_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      strict_in[i] = (s7_ta < s7_big[i]) && (s7_big[i] < s7_ua);
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      vertex_hit      <= HIT_NONE;
      edge_hit        <= HIT_NONE;
      closed_inside   <= s7_closed && !s7_dzero;
      in_circumcircle <= s7_incirc;
      if (s7_dzero) begin
        position_class <= CLASS_DEGEN;
      end else if (&strict_in) begin
        position_class <= CLASS_INSIDE;
      end else if (s7_n1[0] && s7_n0[1] && s7_n0[2]) begin
        position_class <= CLASS_VERTEX;
        vertex_hit     <= 2'd0;
      end else if (s7_n0[0] && s7_n1[1] && s7_n0[2]) begin
        position_class <= CLASS_VERTEX;
        vertex_hit     <= 2'd1;
      end else if (s7_n0[0] && s7_n0[1] && s7_n1[2]) begin
        position_class <= CLASS_VERTEX;
        vertex_hit     <= 2'd2;
      end else if (s7_n0[0]) begin
        position_class <= CLASS_EDGE;
        edge_hit       <= 2'd0;
      end else if (s7_n0[1]) begin
        position_class <= CLASS_EDGE;
        edge_hit       <= 2'd1;
      end else if (s7_n0[2]) begin
        position_class <= CLASS_EDGE;
        edge_hit       <= 2'd2;
      end else begin
        position_class <= CLASS_OUTSIDE;
      end
    end
  end

  // checks
  `ASSERT_HOLDS(a_degen_no_hits, out_valid && (position_class == CLASS_DEGEN), (vertex_hit == HIT_NONE) && (edge_hit == HIT_NONE) && !closed_inside)
  `ASSERT_HOLDS(a_inside_is_closed, out_valid && (position_class == CLASS_INSIDE), closed_inside)
  `ASSERT_HOLDS(a_vertex_hit_match, out_valid, (position_class == CLASS_VERTEX) == (vertex_hit != HIT_NONE))
  `ASSERT_HOLDS(a_edge_hit_match, out_valid, (position_class == CLASS_EDGE) == (edge_hit != HIT_NONE))
  `ASSERT_NEXT(a_stall_keeps_item, vld[7] && !en[8], vld[7] && vld[8])

endmodule
